### rtl/core/lls_pkg.sv
// Shared types and constants for the LUT Laplacian sharpening stream block.
// No dependencies; every other file imports this package.
`default_nettype none

package lls_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 10;
  localparam int MAX_HEIGHT = 512;
  localparam int MIN_DIM    = 3;
  localparam int WCMP_W     = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int PIX_W      = 8;
  localparam int LUT_AW     = 8;
  localparam int LUT_DEPTH  = 256;
  localparam int GAIN_W     = 8;
  localparam int LAP_W      = 11;
  localparam int ACC_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [1:0] KIND_LUT   = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t older;
    pix_t prev;
  } line_word_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic border;
    pix_t centre;
    pix_t up;
    pix_t down;
    pix_t left;
  } s1_t;

endpackage

`default_nettype wire

### rtl/core/lls_if.sv
// Stream channel interfaces: pixel/table input beats and processed pixel output beats.
// Depends on lls_pkg.
`default_nettype none

interface lls_in_if import lls_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  pix_t       lut_index;
  pix_t       lut_value;
  pix_t       pixel_value;

  modport source (output valid, kind, lut_index, lut_value, pixel_value, input ready);
  modport sink   (input valid, kind, lut_index, lut_value, pixel_value, output ready);
endinterface

interface lls_out_if import lls_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic last_pixel;

  modport source (output valid, pixel_out, last_pixel, input ready);
  modport sink   (input valid, pixel_out, last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/core/lls_line_ram.sv
// Combined line store: raw rows r-1 and r-2 in one word per column.
// Synchronous RAM, one write and one registered read per cycle. Depends on lls_pkg.
`default_nettype none

module lls_line_ram import lls_pkg::*; (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [COL_W-1:0] waddr,
  input  wire line_word_t       wdata,
  input  wire logic             re,
  input  wire logic [COL_W-1:0] raddr,
  output line_word_t            rdata
);

  line_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/lls_tone_table.sv
// Tone table: 256-entry RAM with per-entry valid bits; unwritten entries map to identity.
// Registered read, one write port. Depends on lls_pkg.
`default_nettype none

module lls_tone_table import lls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [LUT_AW-1:0] waddr,
  input  wire pix_t              wdata,
  input  wire logic              re,
  input  wire logic [LUT_AW-1:0] raddr,
  output pix_t                   rdata
);

  pix_t              mem [LUT_DEPTH];
  logic [LUT_DEPTH-1:0] vld;
  pix_t              q;
  logic              q_vld;
  logic [LUT_AW-1:0] q_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q      <= mem[raddr];
      q_vld  <= vld[raddr];
      q_addr <= raddr;
    end
  end

  assign rdata = q_vld ? q : pix_t'(q_addr);

endmodule

`default_nettype wire

### rtl/core/lls_sharpen.sv
// Sharpening datapath: Laplacian times gain, then subtract, scale, saturate, output register.
// Two registered stages after the stage-one operands. Depends on lls_pkg, lls_if.
`default_nettype none

module lls_sharpen import lls_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire s1_t               s1,
  input  wire pix_t              tone,
  input  wire pix_t              right,
  input  wire logic [GAIN_W-1:0] gain,
  output logic                   s2_free,
  lls_out_if.source              pix_out
);

  logic [PIX_W+1:0]        nsum;
  logic signed [LAP_W-1:0] lap;
  logic signed [ACC_W-1:0] prod;
  logic                    s2_valid;
  logic                    s2_last;
  pix_t                    s2_tone;
  logic signed [ACC_W-1:0] s2_prod;
  logic signed [ACC_W-1:0] v;
  pix_t                    res;
  logic                    out_valid;
  pix_t                    out_pix;
  logic                    out_last;
  logic                    en_out;

  assign nsum = (PIX_W+2)'(s1.up) + (PIX_W+2)'(s1.down)
              + (PIX_W+2)'(s1.left) + (PIX_W+2)'(right);
  assign lap  = $signed({1'b0, nsum}) - $signed({1'b0, s1.centre, 2'b00});
  assign prod = $signed({1'b0, gain}) * lap;

  assign en_out  = !out_valid || pix_out.ready;
  assign s2_free = en_out || !s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1.valid) begin
      s2_last <= s1.last;
      s2_tone <= tone;
      s2_prod <= s1.border ? '0 : prod;
    end
  end

  assign v = $signed({{(ACC_W-PIX_W-8){1'b0}}, s2_tone, 8'h00}) - s2_prod;

  always_comb begin
    if (v[ACC_W-1]) begin
      res = '0;
    end else if (|v[ACC_W-2:PIX_W+8]) begin
      res = '1;
    end else begin
      res = v[PIX_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) begin
      out_pix  <= res;
      out_last <= s2_last;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.pixel_out  = out_pix;
  assign pix_out.last_pixel = out_last;

endmodule

`default_nettype wire

### rtl/core/lut_laplacian_sharpen_stream_top.sv
// LUT Laplacian sharpening stream, top level: counters, line-store prefetch, tone lookup.
// Pipeline: a releasing beat goes through the stage-one, stage-two and output registers.
// Throughput: one beat per cycle unless stalled; line RAM read prefetches next column.
// Reset: synchronous; counters, pipeline, gain clear; frame size to max; LUT to identity.
// Depends on lls_pkg, lls_if, lls_line_ram, lls_tone_table, lls_sharpen.
`default_nettype none

module lut_laplacian_sharpen_stream_top import lls_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  lls_in_if.sink                     pix_in,
  lls_out_if.source                  pix_out
);

  logic [GAIN_W-1:0] gain_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  height_q;
  logic [COL_W-1:0]  col_q;
  logic [DIM_W-1:0]  row_q;
  pix_t              left_q;
  s1_t               s1_q;
  s1_t               s1_next;

  logic [WCMP_W-1:0] w_ext;
  logic [WCMP_W-1:0] w_eff;
  logic [WCMP_W-1:0] col_ext;
  logic [WCMP_W-1:0] c_sel;
  logic [WCMP_W-1:0] c_plus;
  logic [COL_W-1:0]  c;
  logic [COL_W-1:0]  col_next;
  logic              row_end;
  logic [DIM_W-1:0]  h_eff;
  logic              drain_phase;

  logic              s2_free;
  logic              en1;
  logic              accept;
  logic              pix_act;
  logic              drn_act;
  logic              emit_pix;

  line_word_t        cur;
  line_word_t        line_wdata;
  logic              line_we;
  logic              line_re;
  logic              tone_we;
  logic              tone_re;
  pix_t              tone;

  assign w_ext = WCMP_W'(width_q);
  always_comb begin
    if (w_ext < WCMP_W'(MIN_DIM)) begin
      w_eff = WCMP_W'(MIN_DIM);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
  end

  always_comb begin
    if (height_q < DIM_W'(MIN_DIM)) begin
      h_eff = DIM_W'(MIN_DIM);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign col_ext     = WCMP_W'(col_q);
  assign c_sel       = (col_ext >= w_eff) ? w_eff - 1'b1 : col_ext;
  assign c           = c_sel[COL_W-1:0];
  assign c_plus      = c_sel + 1'b1;
  assign row_end     = c_plus >= w_eff;
  assign col_next    = row_end ? '0 : c_plus[COL_W-1:0];
  assign drain_phase = row_q >= h_eff;

  assign en1          = s2_free || !s1_q.valid;
  assign pix_in.ready = en1;
  assign accept       = pix_in.valid && en1;
  assign pix_act      = accept && pix_in.kind == KIND_PIXEL && !drain_phase;
  assign drn_act      = accept && pix_in.kind == KIND_DRAIN && drain_phase;
  assign emit_pix     = pix_act && row_q != '0;

  assign line_we          = pix_act;
  assign line_wdata.older = cur.prev;
  assign line_wdata.prev  = pix_in.pixel_value;
  assign line_re          = pix_act || drn_act;
  assign tone_we          = accept && pix_in.kind == KIND_LUT;
  assign tone_re          = emit_pix || drn_act;

  lls_line_ram u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (c),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (col_next),
    .rdata (cur)
  );

  lls_tone_table u_tone (
    .clk   (clk),
    .rst   (rst),
    .we    (tone_we),
    .waddr (pix_in.lut_index),
    .wdata (pix_in.lut_value),
    .re    (tone_re),
    .raddr (cur.prev),
    .rdata (tone)
  );

  always_comb begin
    s1_next.valid  = emit_pix || drn_act;
    s1_next.last   = drn_act && row_end;
    s1_next.border = drn_act || row_q == DIM_W'(1) || c == '0 || row_end;
    s1_next.centre = cur.prev;
    s1_next.up     = cur.older;
    s1_next.down   = pix_in.pixel_value;
    s1_next.left   = left_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_q <= '0;
    end else if (en1) begin
      s1_q <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      if (pix_act || drn_act) begin
        col_q <= col_next;
      end
      if (pix_act && row_end) begin
        row_q <= row_q + 1'b1;
      end else if (drn_act && row_end) begin
        row_q <= '0;
      end
      if (emit_pix) begin
        left_q <= cur.prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q   <= '0;
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data;
        CFG_HEIGHT: height_q <= cfg_data;
        default: ;
      endcase
    end
  end

  lls_sharpen u_sharpen (
    .clk     (clk),
    .rst     (rst),
    .s1      (s1_q),
    .tone    (tone),
    .right   (cur.prev),
    .gain    (gain_q),
    .s2_free (s2_free),
    .pix_out (pix_out)
  );

  a_line_port_split: assert property (@(posedge clk) disable iff (rst)
    line_we && line_re |-> c != col_next)
    else $error("line store read and write hit the same column");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_q.valid && !s2_free |=> s1_q.valid)
    else $error("stage-one beat dropped while stalled");

  a_tone_to_s1: assert property (@(posedge clk) disable iff (rst)
    tone_re |=> s1_q.valid)
    else $error("tone lookup issued without a stage-one beat");

endmodule

`default_nettype wire
